// ===== hdl/spq_pkg.sv =====
// package for the sorted max priority queue
// holds default sizes, command and status codes and the cell control struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_VALUE_BITS = 32;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_PUSH_OK   = 2'd0;
    localparam logic [1:0] ST_POP_OK    = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY = 2'd2;
    localparam logic [1:0] ST_PUSH_FULL = 2'd3;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/sorted_max_priority_queue_top.sv =====
// top level of the sorted max priority queue
// a chain of spq_cell instances with the count, handshake and result register
// depends on spq_pkg and spq_cell
//
// usage:
// - input channel in_valid / in_ready carries command (push or pop) and value
// - output channel out_valid / out_ready carries status, popped_value, entry_count
// - every item gives exactly one result, registered when the item is taken
// - one item per cycle while out_ready is high: all cells compare against the pushed value in parallel
//   and shift by one place in the same cycle, so the chain sets the rate
// - the result register holds while out_ready is low; a new item is taken in
//   the cycle that the held result leaves, so a stalled receiver stalls input
// - reset empties the queue and drops any pending result; cell contents are
//   not cleared, the count alone marks which cells hold entries
// - a push on a full queue and a pop on an empty one change nothing
`timescale 1ns / 1ps
`default_nettype none

module sorted_max_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         command,
    input  wire logic signed [VALUE_BITS-1:0] value,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        status,
    output logic signed [VALUE_BITS-1:0]      popped_value,
    output logic [CNT_W-1:0]                  entry_count
);

    logic                         out_valid_reg;
    logic [1:0]                   status_reg;
    logic [1:0]                   status_next;
    logic signed [VALUE_BITS-1:0] popped_reg;
    logic signed [VALUE_BITS-1:0] popped_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;

    logic       accept;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;

    logic signed [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic                         cell_ge    [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = count_reg == CNT_W'(CAPACITY);
    assign empty    = count_reg == '0;

    assign ctrl.push = accept && (command == CMD_PUSH) && !full;
    assign ctrl.pop  = accept && (command == CMD_POP) && !empty;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_BITS-1:0] left_value;
        logic                         left_ge;
        logic signed [VALUE_BITS-1:0] right_value;

        if (i == 0)
        begin : g_head
            assign left_value = value;
            assign left_ge    = 1'b1;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
            assign left_ge    = cell_ge[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        spq_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .push_value  (value),
            .left_value  (left_value),
            .left_ge     (left_ge),
            .right_value (right_value),
            .value       (cell_value[i]),
            .ge          (cell_ge[i])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        popped_next = popped_reg;
        if (accept)
        begin
            popped_next = '0;
            if (command == CMD_PUSH)
            begin
                if (full)
                begin
                    status_next = ST_PUSH_FULL;
                end
                else
                begin
                    status_next = ST_PUSH_OK;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = ST_POP_EMPTY;
                end
                else
                begin
                    status_next = ST_POP_OK;
                    popped_next = cell_value[0];
                    count_next  = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        popped_reg <= popped_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign entry_count  = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item gave no result");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |=> (count_reg == $past(count_reg) - CNT_W'(1)) && (status_reg == ST_POP_OK))
        else $error("pop did not lower the count");

    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.push && ctrl.pop))
        else $error("push and pop in one cycle");

endmodule

`default_nettype wire

// ===== hdl/spq_cell.sv =====
// one storage cell of the sorted chain
// holds one entry, compares it with a pushed value and shifts to or from its neighbours
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int CNT_W      = 7,
    parameter int INDEX      = 0
)
(
    input  wire logic                         clk,
    input  wire cell_ctrl_t                   ctrl,
    input  wire logic [CNT_W-1:0]             count,
    input  wire logic signed [VALUE_BITS-1:0] push_value,
    input  wire logic signed [VALUE_BITS-1:0] left_value,
    input  wire logic                         left_ge,
    input  wire logic signed [VALUE_BITS-1:0] right_value,
    output logic signed [VALUE_BITS-1:0]      value,
    output logic                              ge
);

    logic signed [VALUE_BITS-1:0] value_reg;
    logic signed [VALUE_BITS-1:0] value_next;
    logic                         occupied;

    assign occupied = count > CNT_W'(INDEX);
    // equal entries stay ahead of the new one
    assign ge       = occupied && (value_reg >= push_value);
    assign value    = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.push)
        begin
            if (!ge)
            begin
                value_next = left_ge ? push_value : left_value;
            end
        end
        else if (ctrl.pop)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for sorted_max_priority_queue_top: pushes and pops with random idling and stalls
// a scoreboard class keeps its own sorted copy of the queue and checks every result in order
// depends on spq_pkg and the rtl of the queue
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int CAP = DEF_CAPACITY;
    localparam int VB  = DEF_VALUE_BITS;
    localparam int CW  = $clog2(CAP + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

    typedef struct packed {
        logic [1:0]           status;
        logic signed [VB-1:0] popped;
        logic [CW-1:0]        count;
    } pq_result_t;

    class pq_scoreboard;
        logic signed [VB-1:0] held[$];
        pq_result_t           awaited[$];
        int                   mismatches;
        int                   status_seen[4];

        function new();
            mismatches = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void note_item(logic cmd, logic signed [VB-1:0] val);
            pq_result_t r;
            int pos;
            r.popped = '0;
            if (cmd == CMD_PUSH)
            begin
                if (held.size() >= CAP)
                begin
                    r.status = ST_PUSH_FULL;
                end
                else
                begin
                    // equal values go behind the ones already held
                    pos = 0;
                    while (pos < held.size() && held[pos] >= val) pos++;
                    held.insert(pos, val);
                    r.status = ST_PUSH_OK;
                end
            end
            else if (held.size() == 0)
            begin
                r.status = ST_POP_EMPTY;
            end
            else
            begin
                r.popped = held.pop_front();
                r.status = ST_POP_OK;
            end
            r.count = CW'(held.size());
            status_seen[r.status]++;
            awaited.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic signed [VB-1:0] pv, logic [CW-1:0] cnt);
            pq_result_t e;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d value %0d count %0d", st, pv, cnt);
                return;
            end
            e = awaited.pop_front();
            if (st !== e.status || pv !== e.popped || cnt !== e.count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d value %0d count %0d, got %0d %0d %0d",
                             e.status, e.popped, e.count, st, pv, cnt);
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 command = CMD_PUSH;
    logic signed [VB-1:0] value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           status;
    logic signed [VB-1:0] popped_value;
    logic [CW-1:0]        entry_count;

    int send_idle = 0;
    int recv_idle = 0;
    int hold_cycles = 0;
    int cycles = 0;
    int items_sent = 0;

    pq_scoreboard book = new();

    sorted_max_priority_queue_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .entry_count  (entry_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic send_item(input logic cmd, input logic signed [VB-1:0] val);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        do @(negedge clk); while (!in_ready);
        book.note_item(cmd, val);
        items_sent++;
        @(posedge clk);
    endtask

    task automatic drain_wait();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.outstanding() != 0) @(posedge clk);
    endtask

    function automatic logic signed [VB-1:0] pick_value();
        logic signed [VB-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = int'($urandom_range(40)) - 20;
            2:
            begin
                case ($urandom_range(5))
                    0: v = VMAX;
                    1: v = VMIN;
                    2: v = '0;
                    3: v = -1;
                    4: v = 1;
                    default: v = VMAX - 1;
                endcase
            end
            default: v = $urandom_range(1) ? VMAX - $urandom_range(3) : VMIN + $urandom_range(3);
        endcase
        return v;
    endfunction

    // receiver: random ready, with one long hold-off in the last random phase
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
                book.check_result(status, popped_value, entry_count);
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, book.outstanding());
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int phase_items;
        int seg;
        int len;
        int push_pct;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, extremes, duplicates, drain past empty
        send_item(CMD_POP, VMAX);
        send_item(CMD_PUSH, '0);
        send_item(CMD_PUSH, VMAX);
        send_item(CMD_PUSH, VMIN);
        send_item(CMD_PUSH, -1);
        send_item(CMD_PUSH, 1);
        send_item(CMD_PUSH, VMAX);
        send_item(CMD_PUSH, '0);
        send_item(CMD_PUSH, 32'sh55555555);
        send_item(CMD_PUSH, 32'shAAAAAAAA);
        repeat (10) send_item(CMD_POP, $urandom);
        send_item(CMD_PUSH, VMIN);
        send_item(CMD_PUSH, VMIN);
        send_item(CMD_POP, '0);
        send_item(CMD_POP, VMIN);
        drain_wait();

        // random: fill, drain and mixed stretches under three idling patterns
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 25 : (ph == 1) ? 78 : 0;
            recv_idle = (ph == 0) ? 78 : (ph == 1) ? 25 : 0;
            if (ph == 2) hold_cycles = 250;
            phase_items = 0;
            seg = 0;
            while (phase_items < 310)
            begin
                len = $urandom_range(40, 90);
                if (len > 310 - phase_items) len = 310 - phase_items;
                push_pct = (seg % 3 == 0) ? 90 : (seg % 3 == 1) ? 10 : 50;
                repeat (len)
                    send_item(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP, pick_value());
                phase_items += len;
                seg++;
            end
            drain_wait();
        end

        repeat (10) @(posedge clk);
        $display("%0d items: %0d pushes stored, %0d pushes dropped when full", items_sent,
                 book.status_seen[ST_PUSH_OK], book.status_seen[ST_PUSH_FULL]);
        $display("%0d pops returned a value, %0d pops on an empty queue, %0d mismatches",
                 book.status_seen[ST_POP_OK], book.status_seen[ST_POP_EMPTY], book.mismatches);
        if (book.mismatches == 0 && book.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_max_priority_queue_top.sv
tb/tb.sv
